### hdl/hed_pkg.sv
// Shared types, character codes and helpers for the HTML entity decoder.
package hed_pkg;

	localparam int ENTITY_WINDOW_DEF = 10;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CODE_MIN = 8'd32;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_RESOLVE,
		OP_NUM,
		OP_LIT,
		OP_FLUSH_AMP,
		OP_FLUSH_BYTE,
		OP_LAST
	} hed_op_t;

	typedef struct packed {
		logic    load;
		logic    advance;
		logic    rd_sel;
		hed_op_t op;
	} hed_cmd_t;

	typedef struct packed {
		logic stall;
		logic out_free;
		logic amp;
		logic end_flag;
		logic src_semi;
		logic store_ok;
		logic more;
		logic name_hit;
		logic numeric;
		logic p_more;
		logic num_done;
	} hed_stat_t;

	// {valid, value} of a decimal or hex digit
	function automatic logic [4:0] hed_digit(input logic [7:0] c, input logic hex);
		logic [4:0] r;
		r = '0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (hex && c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else if (hex && c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end
		return r;
	endfunction

endpackage

### hdl/hed_in_if.sv
// Input channel: one text byte per request.
interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;
	modport source (output valid, in_byte, end_of_text, input ready);
	modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

### hdl/hed_out_if.sv
// Output channel: one decoded byte or end marker per request.
interface hed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       run_last;
	logic       text_done;
	modport source (output valid, out_byte, has_byte, run_last, text_done, input ready);
	modport sink (input valid, out_byte, has_byte, run_last, text_done, output ready);
endinterface

### hdl/html_entity_decoder_unit.sv
// Top level of the streaming HTML character entity decoder.
// Bytes of text enter one per request and decoded bytes leave one per request, each
// result tagged with run_last (last result of that input byte) and text_done (last
// result of the text; a bare end marker with has_byte low when the text ends with
// nothing to show). A plain byte takes a push step and a step that hands the final
// result to the output register, where the next byte may be taken. Resolving an
// entity adds a lookup step, then parse steps over the held bytes for a numeric
// name, or steps that replay the held bytes and the ';' for an unknown name.
// A window overflow rescans the ENTITY_WINDOW bytes at one per cycle while the output
// does not stall, through the single read port of the hold buffer; a flush at end
// of text emits the '&' and replays the held bytes. Output stalls hold the sequencer.
module html_entity_decoder_unit import hed_pkg::*; #(
	parameter int ENTITY_WINDOW = ENTITY_WINDOW_DEF
) (
	input logic    clk,
	input logic    arst_n,
	hed_in_if.sink  in_chan,
	hed_out_if.source out_chan
);

	hed_cmd_t  cmd;
	hed_stat_t st;

	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_chan.valid),
		.in_ready (in_chan.ready),
		.st       (st),
		.cmd      (cmd)
	);

	hed_dp #(
		.ENTITY_WINDOW (ENTITY_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_chan.in_byte),
		.in_end    (in_chan.end_of_text),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_chan.valid),
		.out_ready (out_chan.ready),
		.out_byte  (out_chan.out_byte),
		.has_byte  (out_chan.has_byte),
		.run_last  (out_chan.run_last),
		.text_done (out_chan.text_done)
	);

endmodule

### hdl/hed_dp.sv
// Datapath: held bytes, rescan pointer, numeric parser and output staging.
module hed_dp import hed_pkg::*; #(
	parameter int ENTITY_WINDOW = ENTITY_WINDOW_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  hed_cmd_t   cmd,
	output hed_stat_t  st,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       text_done
);

	localparam int CW = $clog2(ENTITY_WINDOW);
	localparam logic [CW-1:0] TOP = CW'(ENTITY_WINDOW - 1);

	logic [7:0]    pend_q [ENTITY_WINDOW];
	logic [CW-1:0] cnt_q, rd_q, p_q;
	logic          amp_q, rescan_q;
	logic [7:0]    cur_q;
	logic          end_q;
	logic          hex_q, ws_q, neg_q, any_q, big_q, pfx_q;
	logic [7:0]    mag_q;
	logic [7:0]    hold_q;
	logic          hold_v_q;
	logic          out_v_q;
	logic [7:0]    out_byte_q;
	logic          has_q, last_q, done_q;

	logic [CW-1:0] rd_addr;
	logic [7:0]    rdat, src;
	logic [4:0]    cnt5;
	logic          p_more, store_ok, more, out_free, stall;
	logic          name_hit, numeric, hex_start;
	logic [7:0]    name_code;
	logic [4:0]    dig;
	logic          is_ws, is_sign, is_x, skip_x, stop, num_done;
	logic [11:0]   prod, sum;
	logic          num_emit;
	logic [7:0]    num_byte;
	logic          emit_v;
	logic [7:0]    emit_b;
	logic          last_push;

	assign rd_addr  = cmd.rd_sel ? rd_q : p_q;
	assign rdat     = pend_q[rd_addr];
	assign src      = rescan_q ? rdat : cur_q;
	assign cnt5     = 5'(cnt_q);
	assign p_more   = p_q < cnt_q;
	assign store_ok = cnt_q != TOP;
	assign more     = rescan_q && rd_q != TOP;
	assign out_free = !out_v_q || out_ready;
	assign stall    = hold_v_q && !out_free;

	// named entities
	always_comb begin
		name_hit  = 1'b1;
		name_code = CH_AMP;
		if (cnt5 == 5'd3 && pend_q[0] == "a" && pend_q[1] == "m" && pend_q[2] == "p") begin
			name_code = CH_AMP;
		end else if (cnt5 == 5'd2 && pend_q[0] == "l" && pend_q[1] == "t") begin
			name_code = CH_LT;
		end else if (cnt5 == 5'd2 && pend_q[0] == "g" && pend_q[1] == "t") begin
			name_code = CH_GT;
		end else if (cnt5 == 5'd4 && pend_q[0] == "q" && pend_q[1] == "u" &&
			pend_q[2] == "o" && pend_q[3] == "t") begin
			name_code = CH_QUOT;
		end else if (cnt5 == 5'd4 && pend_q[0] == "a" && pend_q[1] == "p" &&
			pend_q[2] == "o" && pend_q[3] == "s") begin
			name_code = CH_APOS;
		end else if (cnt5 == 5'd4 && pend_q[0] == "n" && pend_q[1] == "b" &&
			pend_q[2] == "s" && pend_q[3] == "p") begin
			name_code = CH_SPACE;
		end else begin
			name_hit = 1'b0;
		end
	end

	assign numeric   = cnt_q != '0 && pend_q[0] == CH_HASH;
	assign hex_start = cnt5 > 5'd1 && (pend_q[1] == "x" || pend_q[1] == "X");

	// numeric parser, one held byte per step
	assign dig     = hed_digit(rdat, hex_q);
	assign is_ws   = rdat == CH_SPACE || (rdat >= CH_TAB && rdat <= CH_CR);
	assign is_sign = rdat == CH_PLUS || rdat == CH_MINUS;
	assign is_x    = rdat == "x" || rdat == "X";
	// a lone leading 0 in hex mode may be followed by an x that is skipped
	assign skip_x  = hex_q && pfx_q && is_x;
	assign stop    = ws_q ? (!is_ws && !is_sign && !dig[4]) : (!dig[4] && !skip_x);
	assign num_done = !p_more || stop;
	assign prod    = hex_q ? {mag_q, 4'b0} : ({1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0});
	assign sum     = prod + 12'(dig[3:0]);
	assign num_emit = any_q && !neg_q && (big_q || mag_q >= CODE_MIN);
	assign num_byte = big_q ? CH_QMARK : mag_q;

	always_comb begin
		emit_v = 1'b0;
		emit_b = src;
		case (cmd.op)
			OP_PUSH: begin
				if (!amp_q) begin
					emit_v = src != CH_AMP;
				end else if (src != CH_SEMI && !store_ok) begin
					emit_v = 1'b1;
					emit_b = CH_AMP;
				end
			end
			OP_RESOLVE: begin
				if (name_hit) begin
					emit_v = 1'b1;
					emit_b = name_code;
				end else if (!numeric) begin
					emit_v = 1'b1;
					emit_b = CH_AMP;
				end
			end
			OP_NUM: begin
				emit_v = num_done && num_emit;
				emit_b = num_byte;
			end
			OP_LIT: begin
				emit_v = 1'b1;
				emit_b = p_more ? rdat : CH_SEMI;
			end
			OP_FLUSH_AMP: begin
				emit_v = 1'b1;
				emit_b = CH_AMP;
			end
			OP_FLUSH_BYTE: begin
				emit_v = p_more;
				emit_b = rdat;
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
	end

	assign last_push = cmd.op == OP_LAST && (hold_v_q || end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q    <= 1'b0;
			cnt_q    <= '0;
			rescan_q <= 1'b0;
			rd_q     <= '0;
			p_q      <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_PUSH: begin
					if (!amp_q) begin
						if (src == CH_AMP) begin
							amp_q <= 1'b1;
							cnt_q <= '0;
						end
					end else if (src != CH_SEMI) begin
						if (store_ok) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							// window full: drop the '&' and rescan the held bytes
							amp_q    <= 1'b0;
							cnt_q    <= '0;
							rescan_q <= 1'b1;
							rd_q     <= '0;
						end
					end
				end
				OP_RESOLVE: begin
					if (name_hit) begin
						amp_q <= 1'b0;
						cnt_q <= '0;
					end else if (numeric) begin
						p_q <= hex_start ? CW'(2) : CW'(1);
					end else begin
						p_q <= '0;
					end
				end
				OP_NUM: begin
					if (num_done) begin
						amp_q <= 1'b0;
						cnt_q <= '0;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				OP_LIT, OP_FLUSH_BYTE: begin
					if (p_more) begin
						p_q <= p_q + 1'b1;
					end else begin
						amp_q <= 1'b0;
						cnt_q <= '0;
					end
				end
				OP_FLUSH_AMP: begin
					p_q <= '0;
				end
				OP_LAST: begin
					if (end_q) begin
						amp_q <= 1'b0;
						cnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if (cmd.advance) begin
				if (more) begin
					rd_q <= rd_q + 1'b1;
				end else begin
					rescan_q <= 1'b0;
				end
			end
			if (emit_v) begin
				hold_v_q <= 1'b1;
			end else if (cmd.op == OP_LAST) begin
				hold_v_q <= 1'b0;
			end
			if (last_push || (emit_v && hold_v_q)) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= in_byte;
			end_q <= in_end;
		end
		if (cmd.op == OP_PUSH && amp_q && src != CH_SEMI) begin
			if (store_ok) begin
				pend_q[cnt_q] <= src;
			end else begin
				pend_q[TOP] <= src;
			end
		end
		if (cmd.op == OP_RESOLVE && numeric && !name_hit) begin
			hex_q <= hex_start;
			ws_q  <= 1'b1;
			neg_q <= 1'b0;
			any_q <= 1'b0;
			big_q <= 1'b0;
			pfx_q <= 1'b0;
			mag_q <= '0;
		end
		if (cmd.op == OP_NUM && !num_done) begin
			if (ws_q && is_ws) begin
				ws_q <= 1'b1;
			end else if (ws_q && is_sign) begin
				ws_q  <= 1'b0;
				neg_q <= rdat == CH_MINUS;
			end else begin
				ws_q <= 1'b0;
				if (dig[4]) begin
					any_q <= 1'b1;
					mag_q <= sum[7:0];
					big_q <= big_q || sum > 12'd255;
					pfx_q <= hex_q && !any_q && dig[3:0] == 4'd0;
				end else begin
					pfx_q <= 1'b0;
				end
			end
		end
		if (emit_v) begin
			hold_q <= emit_b;
		end
		if (last_push) begin
			out_byte_q <= hold_v_q ? hold_q : 8'd0;
			has_q      <= hold_v_q;
			last_q     <= 1'b1;
			done_q     <= end_q;
		end else if (emit_v && hold_v_q) begin
			out_byte_q <= hold_q;
			has_q      <= 1'b1;
			last_q     <= 1'b0;
			done_q     <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_q;
	assign run_last  = last_q;
	assign text_done = done_q;

	assign st.stall    = stall;
	assign st.out_free = out_free;
	assign st.amp      = amp_q;
	assign st.end_flag = end_q;
	assign st.src_semi = src == CH_SEMI;
	assign st.store_ok = store_ok;
	assign st.more     = more;
	assign st.name_hit = name_hit;
	assign st.numeric  = numeric;
	assign st.p_more   = p_more;
	assign st.num_done = num_done;

	// rescan writes never overtake the read pointer
	a_rescan_order: assert property (@(posedge clk) disable iff (!arst_n)
		rescan_q |-> cnt_q <= rd_q)
		else $error("held-byte write passed rescan pointer");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LAST && end_q) |=> (!amp_q && !hold_v_q))
		else $error("state not cleared at end of text");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready) |-> !(emit_v && hold_v_q) && !last_push)
		else $error("output register overwritten while stalled");

endmodule

### hdl/hed_ctrl.sv
// Controller: sequences push, resolve, literal, numeric and flush steps.
module hed_ctrl import hed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hed_stat_t st,
	output hed_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_PUSH    = 8'b0000_0010,
		S_RESOLVE = 8'b0000_0100,
		S_NUM     = 8'b0000_1000,
		S_LIT     = 8'b0001_0000,
		S_LAST    = 8'b0010_0000,
		S_FLUSH   = 8'b0100_0000,
		S_FBYTE   = 8'b1000_0000
	} hed_state_t;

	hed_state_t state_q, nxt, after;

	assign after = st.more ? S_PUSH : S_LAST;

	always_comb begin
		nxt         = state_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		cmd.rd_sel  = state_q == S_PUSH;
		cmd.op      = OP_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt      = S_PUSH;
				end
			end
			S_PUSH: begin
				if (!st.stall) begin
					cmd.op = OP_PUSH;
					if (st.amp && st.src_semi) begin
						nxt = S_RESOLVE;
					end else if (st.amp && !st.store_ok) begin
						nxt = S_PUSH;
					end else begin
						cmd.advance = 1'b1;
						nxt         = after;
					end
				end
			end
			S_RESOLVE: begin
				if (!st.stall) begin
					cmd.op = OP_RESOLVE;
					if (st.name_hit) begin
						cmd.advance = 1'b1;
						nxt         = after;
					end else if (st.numeric) begin
						nxt = S_NUM;
					end else begin
						nxt = S_LIT;
					end
				end
			end
			S_NUM: begin
				if (!st.stall) begin
					cmd.op = OP_NUM;
					if (st.num_done) begin
						cmd.advance = 1'b1;
						nxt         = after;
					end
				end
			end
			S_LIT: begin
				if (!st.stall) begin
					cmd.op = OP_LIT;
					if (!st.p_more) begin
						cmd.advance = 1'b1;
						nxt         = after;
					end
				end
			end
			S_LAST: begin
				if (st.end_flag && st.amp) begin
					if (!st.stall) begin
						cmd.op = OP_FLUSH_AMP;
						nxt    = S_FBYTE;
					end
				end else if (st.out_free) begin
					// last result goes out; the next byte may be taken at once
					cmd.op   = OP_LAST;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						nxt      = S_PUSH;
					end else begin
						nxt = S_IDLE;
					end
				end
			end
			S_FBYTE: begin
				if (!st.stall) begin
					cmd.op = OP_FLUSH_BYTE;
					if (!st.p_more) begin
						nxt = S_LAST;
					end
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready && in_valid)
		else $error("byte loaded without a request");

	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LAST |-> st.out_free)
		else $error("final result issued while output busy");

	a_advance_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> cmd.op != OP_NONE && !st.stall)
		else $error("advance without a step");

endmodule
